/* rtl/rbsr_pkg.sv */
package rbsr_pkg;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_LOAD = 2'd2;

    localparam logic [1:0] RES_FRAME = 2'd0;
    localparam logic [1:0] RES_GOOD  = 2'd1;
    localparam logic [1:0] RES_BAD   = 2'd2;

    localparam logic [2:0] POS_IDLE  = 3'd0;
    localparam logic [2:0] POS_FIRST = 3'd1;
    localparam logic [2:0] POS_CHECK = 3'd6;

    localparam logic [4:0] FRAME_LAST = 5'd21;
    localparam logic [7:0] SYNC_OUT   = 8'hC0;

    localparam logic [17:0] CLEAR_ON_RESET = 18'h00EF0;
    localparam logic [17:0] SEATBELTS      = 18'h00C00;

    localparam logic [7:0] CMD_CLEAR    = 8'h03;
    localparam logic [7:0] CMD_BELT_TGL = 8'h0A;
    localparam logic [7:0] CMD_BELT_CLR = 8'h0D;

    typedef enum logic [1:0] {
        CMD_PKT,
        CMD_READ,
        CMD_LOAD
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        first_byte;
        logic [7:0]  rx_byte;
        logic [17:0] switch_bits;
        logic [1:0]  motion_select;
    } t_req;

    typedef struct packed {
        logic [1:0] res_kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [3:0] blowers;
        logic [1:0] gun_reaction;
        logic [5:0] lamps;
        logic [1:0] billboard;
    } t_res;

    // One classified request handed from the receive side to the executor.
    typedef struct packed {
        t_cmd_kind       kind;
        logic            good;
        logic [4:0][7:0] hold;
        logic [17:0]     switches;
        logic [1:0]      motion;
    } t_cmd;

    function automatic logic [7:0] cmd_reply(input logic [7:0] code, input logic [7:0] prev);
        logic [7:0] r;
        r = code;
        unique case (code) inside
            8'h01:               r = 8'h01;
            8'h02:               r = 8'h03;
            CMD_CLEAR:           r = prev;
            8'h04, 8'h05, 8'h19: r = 8'h05;
            8'h06:               r = 8'h08;
            8'h08:               r = 8'h0A;
            CMD_BELT_TGL:        r = 8'h0A;
            CMD_BELT_CLR:        r = 8'h0D;
            default:             r = code;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] seat_reply(input logic [7:0] code, input logic [7:0] prev);
        logic [7:0] r;
        r = prev;
        unique case (code) inside
            8'h01, 8'h11: r = 8'd1;
            8'h21:        r = 8'd3;
            8'h31:        r = 8'd5;
            8'h41:        r = 8'd7;
            8'h51:        r = 8'd9;
            8'h61:        r = 8'd11;
            default:      r = prev;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] frame_byte(
        input logic [4:0]  idx,
        input logic [7:0]  cmd_ans,
        input logic [7:0]  seat_ans,
        input logic [17:0] sw,
        input logic [1:0]  motion
    );
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] r;
        b4 = {1'b0, sw[5:1], motion == 2'd2, sw[0]};
        b5 = sw[13:6];
        b6 = {motion == 2'd0, motion == 2'd1, 1'b0, sw[17:15], 1'b0, sw[14]};
        unique case (idx)
            5'd0:       r = SYNC_OUT;
            5'd2:       r = cmd_ans;
            5'd3:       r = seat_ans;
            5'd4:       r = b4;
            5'd5:       r = b5;
            5'd6:       r = b6;
            FRAME_LAST: r = cmd_ans ^ seat_ans ^ b4 ^ b5 ^ b6;
            default:    r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ride_board_serial_responder_core.sv */
// Device end of a cabinet ride link. Requests are taken one per cycle while full is low:
// host packet bytes are framed and checked on the receive side, and every request that
// does work (a finished packet, a status read, a switch load) is queued in order for the
// executor. A finished packet gives one result, accepted or checksum error, with the
// output groups as latched after that packet. A status read gives 22 frame bytes, one per
// cycle while the result buffer has room, the last one flagged; the executor's frame sequencer
// sets this figure, and the requests queued behind a read wait for it while new ones keep arriving
// until the queue of QUEUE_DEPTH entries fills. Results wait in a two-entry buffer until popped.
module ride_board_serial_responder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  rbsr_pkg::t_req i_req,
    output logic           empty,
    input  logic           pop,
    output rbsr_pkg::t_res o_res
);
    import rbsr_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_valid;
    t_cmd cmd_out;
    logic cmd_take;

    assign accept = push && !full;

    rbsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_req),
        .o_cmd_valid(cmd_push),
        .o_cmd      (cmd_in)
    );

    rbsr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (cmd_push),
        .i_data (cmd_in),
        .o_full (full),
        .i_rd   (cmd_take),
        .o_valid(cmd_valid),
        .o_data (cmd_out)
    );

    rbsr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd_out),
        .o_cmd_take (cmd_take),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res)
    );

    a_take_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("executor took a request from an empty queue");

    a_last_is_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.last) |-> (o_res.res_kind == RES_FRAME))
        else $error("last flag on a result that is not a frame byte");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queue or result buffer not clear after reset");

    a_pkt_result_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_res.res_kind == RES_GOOD || o_res.res_kind == RES_BAD))
        |-> (o_res.tx_byte == 8'h00))
        else $error("packet result carries a frame byte");

endmodule

/* rtl/rbsr_front.sv */
module rbsr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  rbsr_pkg::t_req i_req,
    output logic          o_cmd_valid,
    output rbsr_pkg::t_cmd o_cmd
);
    import rbsr_pkg::*;

    logic [2:0]      r_pos;
    logic [2:0]      n_pos;
    logic [7:0]      r_xor;
    logic [7:0]      n_xor;
    logic [4:0][7:0] r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
            r_xor <= 8'h00;
        end else begin
            r_pos <= n_pos;
            r_xor <= n_xor;
        end
    end

    // Packet bytes one to five are held until the check byte arrives.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 5; i++) begin
            if (i_accept && i_req.req_type == REQ_BYTE && !i_req.first_byte
                && r_pos == 3'(i + 1)) begin
                r_hold[i] <= i_req.rx_byte;
            end
        end
    end

    always_comb begin
        n_pos            = r_pos;
        n_xor            = r_xor;
        o_cmd_valid      = 1'b0;
        o_cmd.kind       = CMD_LOAD;
        o_cmd.good       = i_req.rx_byte == r_xor;
        o_cmd.hold       = r_hold;
        o_cmd.switches   = i_req.switch_bits;
        o_cmd.motion     = i_req.motion_select;
        if (i_accept) begin
            unique case (i_req.req_type)
                REQ_BYTE: begin
                    if (i_req.first_byte) begin
                        n_pos = POS_FIRST;
                        n_xor = 8'h00;
                    end else if (r_pos >= POS_FIRST && r_pos < POS_CHECK) begin
                        n_pos = r_pos + 3'd1;
                        n_xor = r_xor ^ i_req.rx_byte;
                    end else if (r_pos == POS_CHECK) begin
                        n_pos       = POS_IDLE;
                        n_xor       = 8'h00;
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = CMD_PKT;
                    end else begin
                        n_pos = POS_IDLE;
                    end
                end
                REQ_READ: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = CMD_READ;
                end
                REQ_LOAD: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = CMD_LOAD;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/rbsr_queue.sv */
module rbsr_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  rbsr_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output rbsr_pkg::t_cmd o_data
);
    import rbsr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CW'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/rbsr_back.sv */
module rbsr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  rbsr_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    output logic           empty,
    input  logic           pop,
    output rbsr_pkg::t_res o_res
);
    import rbsr_pkg::*;

    logic [7:0]  r_cmd_code;
    logic [7:0]  n_cmd_code;
    logic [7:0]  r_seat_code;
    logic [7:0]  n_seat_code;
    logic [7:0]  r_cmd_ans;
    logic [7:0]  n_cmd_ans;
    logic [7:0]  r_seat_ans;
    logic [7:0]  n_seat_ans;
    logic [17:0] r_switch;
    logic [17:0] n_switch;
    logic [1:0]  r_motion;
    logic [1:0]  n_motion;
    logic [13:0] r_latch;
    logic [13:0] n_latch;
    logic        r_reading;
    logic        n_reading;
    logic [4:0]  r_idx;
    logic [4:0]  n_idx;

    // Two-entry result buffer so that production is not tied to pop.
    t_res        r_ob [2];
    logic        r_ob_rd;
    logic        r_ob_wr;
    logic [1:0]  r_ob_cnt;
    logic        room;
    logic        emit;
    logic        popped;
    t_res        emit_res;

    assign room       = r_ob_cnt != 2'd2;
    assign empty      = r_ob_cnt == 2'd0;
    assign popped     = pop && !empty;
    assign o_res      = r_ob[r_ob_rd];
    assign o_cmd_take = !r_reading && i_cmd_valid && room;

    always_comb begin
        logic [7:0] eff_cmd;
        logic [7:0] eff_seat;
        logic [1:0] bb;
        logic [4:0] byte_idx;
        n_cmd_code  = r_cmd_code;
        n_seat_code = r_seat_code;
        n_cmd_ans   = r_cmd_ans;
        n_seat_ans  = r_seat_ans;
        n_switch    = r_switch;
        n_motion    = r_motion;
        n_latch     = r_latch;
        n_reading   = r_reading;
        n_idx       = r_idx;
        emit        = 1'b0;
        byte_idx    = r_idx;
        eff_cmd     = i_cmd.good ? i_cmd.hold[0] : r_cmd_code;
        eff_seat    = i_cmd.good ? i_cmd.hold[1] : r_seat_code;
        bb          = 2'd0;
        if (i_cmd.hold[3][7]) begin
            bb = i_cmd.hold[3][0] ? 2'd2 : (i_cmd.hold[3][1] ? 2'd3 : 2'd1);
        end
        if (r_reading && room) begin
            emit = 1'b1;
            n_idx = r_idx + 5'd1;
            if (r_idx == FRAME_LAST) begin
                n_reading = 1'b0;
            end
        end else if (o_cmd_take) begin
            unique case (i_cmd.kind)
                CMD_PKT: begin
                    emit = 1'b1;
                    if (i_cmd.good) begin
                        n_cmd_code  = eff_cmd;
                        n_seat_code = eff_seat;
                        n_latch     = {bb, i_cmd.hold[4][5:0], i_cmd.hold[2][5:0]};
                    end
                    n_cmd_ans  = cmd_reply(eff_cmd, r_cmd_ans);
                    n_seat_ans = seat_reply(eff_seat, r_seat_ans);
                    if (eff_cmd == CMD_CLEAR) begin
                        n_switch = r_switch & ~CLEAR_ON_RESET;
                    end else if (eff_cmd == CMD_BELT_TGL) begin
                        n_switch = r_switch ^ SEATBELTS;
                    end else if (eff_cmd == CMD_BELT_CLR) begin
                        n_switch = r_switch & ~SEATBELTS;
                    end
                end
                CMD_READ: begin
                    // The sync byte goes out as the request is taken.
                    emit      = 1'b1;
                    byte_idx  = 5'd0;
                    n_reading = 1'b1;
                    n_idx     = 5'd1;
                end
                CMD_LOAD: begin
                    n_switch = i_cmd.switches;
                    n_motion = i_cmd.motion;
                end
                default: begin
                end
            endcase
        end
        emit_res.res_kind     = RES_FRAME;
        emit_res.tx_byte      = frame_byte(byte_idx, r_cmd_ans, r_seat_ans, r_switch, r_motion);
        emit_res.last         = byte_idx == FRAME_LAST;
        if (!r_reading && i_cmd.kind == CMD_PKT) begin
            emit_res.res_kind = i_cmd.good ? RES_GOOD : RES_BAD;
            emit_res.tx_byte  = 8'h00;
            emit_res.last     = 1'b0;
        end
        emit_res.blowers      = n_latch[3:0];
        emit_res.gun_reaction = n_latch[5:4];
        emit_res.lamps        = n_latch[11:6];
        emit_res.billboard    = n_latch[13:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_code  <= 8'h00;
            r_seat_code <= 8'h00;
            r_cmd_ans   <= 8'h00;
            r_seat_ans  <= 8'h00;
            r_switch    <= 18'h0;
            r_motion    <= 2'd0;
            r_latch     <= 14'h0;
            r_reading   <= 1'b0;
            r_idx       <= 5'd0;
            r_ob_rd     <= 1'b0;
            r_ob_wr     <= 1'b0;
            r_ob_cnt    <= 2'd0;
        end else begin
            r_cmd_code  <= n_cmd_code;
            r_seat_code <= n_seat_code;
            r_cmd_ans   <= n_cmd_ans;
            r_seat_ans  <= n_seat_ans;
            r_switch    <= n_switch;
            r_motion    <= n_motion;
            r_latch     <= n_latch;
            r_reading   <= n_reading;
            r_idx       <= n_idx;
            if (emit) begin
                r_ob_wr <= ~r_ob_wr;
            end
            if (popped) begin
                r_ob_rd <= ~r_ob_rd;
            end
            if (emit && !popped) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (popped && !emit) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob[r_ob_wr] <= emit_res;
        end
    end

endmodule

/* test/ride_board_serial_responder_core_tb.sv */
module ride_board_serial_responder_core_tb;
    import rbsr_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int IDLE_PCT      = 36;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] MSEL_OFF    = 2'd0;
    localparam logic [1:0] MSEL_MILD   = 2'd1;
    localparam logic [1:0] MSEL_NORMAL = 2'd2;
    localparam logic [1:0] MSEL_SPARE  = 2'd3;

    localparam logic [1:0] BOARD_OFF   = 2'd0;
    localparam logic [1:0] BOARD_RED   = 2'd1;
    localparam logic [1:0] BOARD_GREEN = 2'd2;
    localparam logic [1:0] BOARD_BLUE  = 2'd3;

    localparam logic [9:0][7:0] KNOWN_COMMANDS = {
        8'h01, 8'h02, CMD_CLEAR, 8'h04, 8'h05, 8'h19, 8'h06, 8'h08, CMD_BELT_TGL, CMD_BELT_CLR
    };
    localparam logic [6:0][7:0] KNOWN_SEATS = {
        8'h01, 8'h11, 8'h21, 8'h31, 8'h41, 8'h51, 8'h61
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    logic full;
    logic empty;
    t_req i_req   = '0;
    t_res o_res;

    // Outputs as they stood just before the next rising edge.
    logic smp_full;
    logic smp_empty;
    t_res smp_res;

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    int items_sent  = 0;
    int fail_count  = 0;

    t_res expected_responses[$];
    t_res next_expected;

    // Predicted device state.
    logic [2:0]  pkt_pos     = POS_IDLE;
    logic [7:0]  pkt_xor     = '0;
    logic [7:0]  pkt_hold [5];
    logic [7:0]  cmd_code    = '0;
    logic [7:0]  seat_code   = '0;
    logic [7:0]  cmd_answer  = '0;
    logic [7:0]  seat_answer = '0;
    logic [17:0] sw_state    = '0;
    logic [1:0]  motion      = MSEL_OFF;
    logic [3:0]  lat_blowers = '0;
    logic [1:0]  lat_gun     = '0;
    logic [5:0]  lat_lamps   = '0;
    logic [1:0]  lat_board   = BOARD_OFF;

    ride_board_serial_responder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        smp_full  = full;
        smp_empty = empty;
        smp_res   = o_res;
    end

    function automatic t_res make_response(input logic [1:0] kind, input logic [7:0] data,
                                           input logic fin);
        t_res r;
        r.res_kind     = kind;
        r.tx_byte      = data;
        r.last         = fin;
        r.blowers      = lat_blowers;
        r.gun_reaction = lat_gun;
        r.lamps        = lat_lamps;
        r.billboard    = lat_board;
        return r;
    endfunction

    task automatic predict_responses(input t_req r);
        logic       good;
        logic [7:0] frame [22];
        logic [7:0] sum;
        int         i;
        case (r.req_type)
            REQ_BYTE: begin
                if (r.first_byte) begin
                    pkt_pos = POS_FIRST;
                    pkt_xor = '0;
                end else if (pkt_pos >= POS_FIRST && pkt_pos < POS_CHECK) begin
                    pkt_hold[int'(pkt_pos) - 1] = r.rx_byte;
                    pkt_xor = pkt_xor ^ r.rx_byte;
                    pkt_pos = pkt_pos + 3'd1;
                end else if (pkt_pos == POS_CHECK) begin
                    good    = (r.rx_byte == pkt_xor);
                    pkt_pos = POS_IDLE;
                    pkt_xor = '0;
                    if (good) begin
                        cmd_code    = pkt_hold[0];
                        seat_code   = pkt_hold[1];
                        lat_blowers = pkt_hold[2][3:0];
                        lat_gun     = pkt_hold[2][5:4];
                        lat_lamps   = pkt_hold[4][5:0];
                        if (!pkt_hold[3][7]) begin
                            lat_board = BOARD_OFF;
                        end else if (pkt_hold[3][0]) begin
                            lat_board = BOARD_GREEN;
                        end else if (pkt_hold[3][1]) begin
                            lat_board = BOARD_BLUE;
                        end else begin
                            lat_board = BOARD_RED;
                        end
                    end
                    // The reply rules run on the latched codes even after a bad check.
                    case (cmd_code)
                        8'h01:               cmd_answer = 8'h01;
                        8'h02:               cmd_answer = 8'h03;
                        CMD_CLEAR:           sw_state = sw_state & ~CLEAR_ON_RESET;
                        8'h04, 8'h05, 8'h19: cmd_answer = 8'h05;
                        8'h06:               cmd_answer = 8'h08;
                        8'h08:               cmd_answer = 8'h0A;
                        CMD_BELT_TGL: begin
                            cmd_answer = CMD_BELT_TGL;
                            sw_state   = sw_state ^ SEATBELTS;
                        end
                        CMD_BELT_CLR: begin
                            cmd_answer = CMD_BELT_CLR;
                            sw_state   = sw_state & ~SEATBELTS;
                        end
                        default:             cmd_answer = cmd_code;
                    endcase
                    case (seat_code)
                        8'h01, 8'h11: seat_answer = 8'd1;
                        8'h21:        seat_answer = 8'd3;
                        8'h31:        seat_answer = 8'd5;
                        8'h41:        seat_answer = 8'd7;
                        8'h51:        seat_answer = 8'd9;
                        8'h61:        seat_answer = 8'd11;
                        default:      ;
                    endcase
                    expected_responses.push_back(
                        make_response(good ? RES_GOOD : RES_BAD, 8'h00, 1'b0));
                end else begin
                    pkt_pos = POS_IDLE;
                end
            end
            REQ_READ: begin
                for (i = 0; i < 22; i++) frame[i] = 8'h00;
                frame[0] = SYNC_OUT;
                frame[2] = cmd_answer;
                frame[3] = seat_answer;
                frame[4] = {1'b0, sw_state[5:1], motion == MSEL_NORMAL, sw_state[0]};
                frame[5] = sw_state[13:6];
                frame[6] = {motion == MSEL_OFF, motion == MSEL_MILD, 1'b0,
                            sw_state[17:15], 1'b0, sw_state[14]};
                sum = 8'h00;
                for (i = 1; i < int'(FRAME_LAST); i++) sum = sum ^ frame[i];
                frame[FRAME_LAST] = sum;
                for (i = 0; i < 22; i++) begin
                    expected_responses.push_back(
                        make_response(RES_FRAME, frame[i], i == int'(FRAME_LAST)));
                end
            end
            REQ_LOAD: begin
                sw_state = r.switch_bits;
                motion   = r.motion_select;
            end
            default: ;
        endcase
    endtask

    function automatic t_req mk_req(input logic [1:0] kind, input logic first,
                                    input logic [7:0] data);
        t_req r;
        r.req_type      = kind;
        r.first_byte    = first;
        r.rx_byte       = data;
        r.switch_bits   = 18'($urandom_range(18'h3FFFF));
        r.motion_select = 2'($urandom_range(3));
        return r;
    endfunction

    // The request stays on the bus until an edge sees push high and full low.
    task automatic send_req(input t_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        do begin
            @(posedge i_clk);
        end while (smp_full !== 1'b0);
        predict_responses(r);
        if (r.req_type != REQ_UNUSED) items_sent++;
    endtask

    task automatic send_load(input logic [17:0] levels, input logic [1:0] mode);
        t_req r;
        r = mk_req(REQ_LOAD, 1'($urandom_range(1)), 8'($urandom_range(255)));
        r.switch_bits   = levels;
        r.motion_select = mode;
        send_req(r);
    endtask

    // A cut_at below five drops the packet after that many body bytes.
    task automatic send_packet(input logic [4:0][7:0] body, input bit corrupt,
                               input int cut_at, input bit mixed);
        logic [7:0] check;
        int         i;
        check = 8'h00;
        send_req(mk_req(REQ_BYTE, 1'b1, 8'($urandom_range(255))));
        for (i = 0; i < 5; i++) begin
            if (i == cut_at) return;
            if (mixed && $urandom_range(15) == 0) begin
                send_req(mk_req($urandom_range(1) ? REQ_READ : REQ_LOAD,
                                1'($urandom_range(1)), 8'($urandom_range(255))));
            end
            send_req(mk_req(REQ_BYTE, 1'b0, body[i]));
            check = check ^ body[i];
        end
        if (corrupt) check = check ^ 8'($urandom_range(255, 1));
        send_req(mk_req(REQ_BYTE, 1'b0, check));
    endtask

    task automatic wait_for_drain;
        while (expected_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_switch_loads;
        send_load(18'h3FFFF, MSEL_NORMAL);
        send_req(mk_req(REQ_READ, 1'b0, 8'h00));
        send_load(18'h00000, MSEL_SPARE);
        send_req(mk_req(REQ_READ, 1'b1, 8'hFF));
        send_req(mk_req(REQ_UNUSED, 1'b1, 8'hFF));
    endtask

    task automatic test_host_packets;
        send_load(18'h3FFFF, MSEL_MILD);
        // A plain byte with no packet open is dropped.
        send_req(mk_req(REQ_BYTE, 1'b0, 8'hFF));
        // This partial packet is abandoned when the next sync arrives.
        send_req(mk_req(REQ_BYTE, 1'b1, 8'h00));
        send_req(mk_req(REQ_BYTE, 1'b0, 8'h12));
        send_packet({8'hFF, 8'h81, 8'hFF, 8'h61, CMD_BELT_TGL}, 1'b0, 5, 1'b0);
        send_packet({8'h00, 8'h82, 8'h00, 8'h00, 8'hFF}, 1'b1, 5, 1'b0);
        send_req(mk_req(REQ_READ, 1'b0, 8'h00));
    endtask

    task automatic test_random_traffic(input int n);
        int               stop_at;
        int               pick;
        logic [4:0][7:0]  body;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                body = {8'($urandom), 32'($urandom)};
                if ($urandom_range(3) != 0) body[0] = KNOWN_COMMANDS[$urandom_range(9)];
                if ($urandom_range(3) != 0) body[1] = KNOWN_SEATS[$urandom_range(6)];
                body[3][7] = ($urandom_range(3) != 0);
                send_packet(body, $urandom_range(9) == 0,
                            ($urandom_range(9) == 0) ? $urandom_range(4) : 5, 1'b1);
            end else if (pick < 80) begin
                send_req(mk_req(REQ_READ, 1'($urandom_range(1)), 8'($urandom_range(255))));
            end else if (pick < 88) begin
                send_load(18'($urandom_range(18'h3FFFF)), 2'($urandom_range(3)));
            end else if (pick < 95) begin
                send_req(mk_req(REQ_BYTE, $urandom_range(3) == 0, 8'($urandom_range(255))));
            end else begin
                send_req(mk_req(REQ_UNUSED, 1'($urandom_range(1)), 8'($urandom_range(255))));
            end
        end
    endtask

    task automatic test_no_idle_stretch;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(50);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_drain_pause;
        push <= 1'b0;
        wait_for_drain();
        @(posedge i_clk);
        test_random_traffic(40);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (pop && smp_empty === 1'b0) begin
            if (expected_responses.size() == 0) begin
                $error("response popped with none pending");
                fail_count++;
            end else begin
                next_expected = expected_responses.pop_front();
                check_field("res_kind", 8'(next_expected.res_kind), 8'(smp_res.res_kind));
                check_field("tx_byte", next_expected.tx_byte, smp_res.tx_byte);
                check_field("last", 8'(next_expected.last), 8'(smp_res.last));
                check_field("blowers", 8'(next_expected.blowers), 8'(smp_res.blowers));
                check_field("gun_reaction", 8'(next_expected.gun_reaction),
                            8'(smp_res.gun_reaction));
                check_field("lamps", 8'(next_expected.lamps), 8'(smp_res.lamps));
                check_field("billboard", 8'(next_expected.billboard),
                            8'(smp_res.billboard));
            end
        end
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Ends the run if neither side moves a request or a response for too long.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && smp_full === 1'b0) || (pop && smp_empty === 1'b0)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_switch_loads();
        test_host_packets();
        test_random_traffic(90);
        test_no_idle_stretch();
        test_drain_pause();
        push <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_responses.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
